// File: rtl/cbc_pkg.sv
// Package for the 3x3 convolution / blend / clamp unit.
// Holds shared constants, field widths and the register index codes; no dependencies.
package cbc_pkg;

   localparam int MAX_WIDTH_DEF    = 4096;
   localparam int MAX_HEIGHT_DEF   = 4096;
   localparam int CHANNEL_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF    = 12;

   // Fixed field widths
   localparam int WEIGHT_BITS = 16;
   localparam int CSR_DATA_BITS = 48;
   localparam int DIM_BITS = 13;

   typedef enum logic [2:0] {
      REG_WEIGHTS_TOP = 3'd0,
      REG_WEIGHTS_MID = 3'd1,
      REG_WEIGHTS_BOT = 3'd2,
      REG_FRAME_WIDTH = 3'd3,
      REG_FRAME_HEIGHT = 3'd4
   } csr_index_type;

   localparam logic [0:0] OP_PIXEL = 1'b0;
   localparam logic [0:0] OP_DRAIN = 1'b1;

endpackage

// File: rtl/cbc_if.sv
// Valid/ready stream interfaces for the request and response channels.
// Depends on cbc_pkg for the default widths.
interface cbc_req_if
   import cbc_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) ();
   logic valid;
   logic ready;
   logic opcode;
   logic signed [CHANNEL_BITS-1:0] in_red;
   logic signed [CHANNEL_BITS-1:0] in_green;
   logic signed [CHANNEL_BITS-1:0] in_blue;
   logic signed [CHANNEL_BITS-1:0] in_alpha;
   logic [FRAC_BITS:0] blend_factor;
   modport source (output valid, opcode, in_red, in_green, in_blue, in_alpha, blend_factor,
                   input ready);
   modport sink (input valid, opcode, in_red, in_green, in_blue, in_alpha, blend_factor,
                 output ready);
endinterface

interface cbc_rsp_if
   import cbc_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) ();
   logic valid;
   logic ready;
   logic [CHANNEL_BITS-2:0] out_red;
   logic [CHANNEL_BITS-2:0] out_green;
   logic [CHANNEL_BITS-2:0] out_blue;
   logic [CHANNEL_BITS-2:0] out_alpha;
   logic frame_done;
   modport source (output valid, out_red, out_green, out_blue, out_alpha, frame_done,
                   input ready);
   modport sink (input valid, out_red, out_green, out_blue, out_alpha, frame_done,
                 output ready);
endinterface

// File: rtl/conv3x3_blend_clamp_unit.sv
// Top level of the 3x3 convolution / blend / clamp unit: line memories, window,
// multiply-accumulate sequencer. Depends on cbc_pkg and cbc_if.sv.
//
// Pixels enter in raster order; the result for a pixel leaves W+1 transfers later
// (W = frame width), and drain transfers (opcode 1) after the last pixel flush the
// final row. Each transfer occupies the unit, when it yields a result, for the accept
// cycle (which reads the two line memories and the factor memory), a write-back and
// window shift step, an accumulator clear step, nine multiply-accumulate steps over
// the window through one shared multiplier per channel, the blend multiply and a
// round/clamp step; when it yields none, it ends after the accumulator clear step.
// An early drain is dropped in its accept cycle. The result sits in an output
// register, so the next transfer is accepted while it waits; the unit then holds in
// its round/clamp step until the previous result has left. No clearing pass after
// reset.
module conv3x3_blend_clamp_unit
   import cbc_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   cbc_req_if.sink req,
   cbc_rsp_if.source rsp,
   input  logic csr_write_enable,
   input  logic [2:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_write_data
);

   localparam int CB = CHANNEL_BITS;
   localparam int FB = FRAC_BITS + 1;
   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 1);
   localparam int PW = 4 * CB;
   localparam int PRODW = CB + WEIGHT_BITS;
   localparam int ACCW = PRODW + 4;
   localparam int BLW = ACCW + FB + 2;

   typedef logic signed [CB-1:0] chan_type;
   typedef chan_type [3:0] pix_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_READ  = 6'b000010,
      ST_SHIFT = 6'b000100,
      ST_MAC   = 6'b001000,
      ST_BLEND = 6'b010000,
      ST_ROUND = 6'b100000
   } state_type;

   // Configuration registers
   logic [CSR_DATA_BITS-1:0] wt_ff [3];
   logic [DIM_BITS-1:0] width_reg_ff, height_reg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wt_ff[0] <= '0;
         wt_ff[1] <= CSR_DATA_BITS'(1 << FRAC_BITS);
         wt_ff[2] <= '0;
         width_reg_ff <= DIM_BITS'(4096);
         height_reg_ff <= DIM_BITS'(4096);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_WEIGHTS_TOP: wt_ff[0] <= csr_write_data;
            REG_WEIGHTS_MID: wt_ff[1] <= csr_write_data;
            REG_WEIGHTS_BOT: wt_ff[2] <= csr_write_data;
            REG_FRAME_WIDTH: width_reg_ff <= csr_write_data[DIM_BITS-1:0];
            REG_FRAME_HEIGHT: height_reg_ff <= csr_write_data[DIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Effective frame size
   logic [CW-1:0] w_eff;
   logic [RW-1:0] h_eff;
   always_comb begin
      if (width_reg_ff == '0) w_eff = CW'(1);
      else if (32'(width_reg_ff) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
      else w_eff = CW'(width_reg_ff);
      if (height_reg_ff == '0) h_eff = RW'(1);
      else if (32'(height_reg_ff) > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
      else h_eff = RW'(height_reg_ff);
   end

   state_type state_ff, state_in;
   logic [CW-1:0] in_col_ff;
   logic [RW:0] in_row_ff;
   logic [CW-1:0] out_col_ff;
   logic [RW-1:0] out_row_ff;
   logic [3:0] step_ff;
   pix_type win_ff [3][3];
   logic [FB-1:0] win_fac_ff [3];
   pix_type px_ff;
   logic [FB-1:0] px_fac_ff;
   logic [AW-1:0] addr_ff;
   logic emit_ff;

   // Line memories
   logic [PW-1:0] mem_one [MAX_WIDTH];
   logic [PW-1:0] mem_two [MAX_WIDTH];
   logic [FB-1:0] mem_fac [MAX_WIDTH];
   logic [PW-1:0] rd_one_ff, rd_two_ff;
   logic [FB-1:0] rd_fac_ff;

   // Output register
   logic out_valid_ff;
   logic [CB-2:0] out_ch_ff [4];
   logic out_done_ff;

   // Accept logic: any idle cycle; the output register is checked at round time
   logic accept, eff_pixel, drain_skip, out_free;
   logic [CW-1:0] c_wrap;
   logic [RW:0] r_wrap;
   assign req.ready = (state_ff == ST_IDLE);
   assign accept = req.valid && req.ready;
   assign out_free = !out_valid_ff || rsp.ready;
   assign drain_skip = req.opcode && (in_row_ff < (RW+1)'(h_eff));
   assign eff_pixel = !req.opcode && (in_row_ff < (RW+1)'(h_eff));
   always_comb begin
      c_wrap = in_col_ff;
      r_wrap = in_row_ff;
      if (in_col_ff >= w_eff) begin
         c_wrap = '0;
         r_wrap = in_row_ff + 1'b1;
      end
   end

   // Memory read, then write-back of the shifted rows
   always_ff @(posedge clock) begin
      if (accept && !drain_skip) begin
         rd_one_ff <= mem_one[c_wrap[AW-1:0]];
         rd_two_ff <= mem_two[c_wrap[AW-1:0]];
         rd_fac_ff <= mem_fac[c_wrap[AW-1:0]];
      end
      if (state_ff == ST_READ) begin
         mem_two[addr_ff] <= rd_one_ff;
         mem_one[addr_ff] <= px_ff;
         mem_fac[addr_ff] <= px_fac_ff;
      end
   end

   // Multiply-accumulate datapath, one product per channel per step
   logic [1:0] rsel [3];
   logic [1:0] csel [3];
   logic [1:0] si, sj;
   logic signed [ACCW-1:0] acc_ff [4];
   logic signed [BLW-1:0] bl_ff [4];
   logic signed [WEIGHT_BITS-1:0] wsel;
   logic signed [ACCW-FRAC_BITS-1:0] filt [4];
   logic signed [FB+1:0] fac_s, onem_s;

   always_comb begin
      rsel[0] = (out_row_ff == '0) ? 2'd1 : 2'd0;
      rsel[1] = 2'd1;
      rsel[2] = (out_row_ff + 1'b1 >= h_eff) ? 2'd1 : 2'd2;
      csel[0] = (out_col_ff == '0) ? 2'd1 : 2'd0;
      csel[1] = 2'd1;
      csel[2] = (CW'(out_col_ff + 1'b1) >= w_eff) ? 2'd1 : 2'd2;
      // step to window row and column
      unique case (step_ff)
         4'd0: begin si = 2'd0; sj = 2'd0; end
         4'd1: begin si = 2'd0; sj = 2'd1; end
         4'd2: begin si = 2'd0; sj = 2'd2; end
         4'd3: begin si = 2'd1; sj = 2'd0; end
         4'd4: begin si = 2'd1; sj = 2'd1; end
         4'd5: begin si = 2'd1; sj = 2'd2; end
         4'd6: begin si = 2'd2; sj = 2'd0; end
         4'd7: begin si = 2'd2; sj = 2'd1; end
         4'd8: begin si = 2'd2; sj = 2'd2; end
         default: begin si = 2'd0; sj = 2'd0; end
      endcase
      wsel = wt_ff[si][WEIGHT_BITS*(2-sj) +: WEIGHT_BITS];
      fac_s = (FB+2)'(win_fac_ff[1]);
      onem_s = (FB+2)'(1 << FRAC_BITS) - fac_s;
      for (int k = 0; k < 4; k++)
         filt[k] = (ACCW-FRAC_BITS)'((acc_ff[k] + (ACCW)'(1 << (FRAC_BITS-1)))
                                     >>> FRAC_BITS);
   end

   logic frame_done_now;
   assign frame_done_now = (CW'(out_col_ff + 1'b1) >= w_eff) && (out_row_ff + 1'b1 >= h_eff);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept && !drain_skip) state_in = ST_READ;
         ST_READ:  state_in = ST_SHIFT;
         ST_SHIFT: state_in = emit_ff ? ST_MAC : ST_IDLE;
         ST_MAC:   if (step_ff == 4'd8) state_in = ST_BLEND;
         ST_BLEND: state_in = ST_ROUND;
         ST_ROUND: state_in = out_free ? ST_IDLE : ST_ROUND;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         in_col_ff <= '0;
         in_row_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         step_ff <= '0;
         out_valid_ff <= 1'b0;
         emit_ff <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            win_fac_ff[r] <= '0;
            for (int c = 0; c < 3; c++) win_ff[r][c] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_ROUND && out_free) out_valid_ff <= 1'b1;
         else if (rsp.valid && rsp.ready) out_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (accept && !drain_skip) begin
               addr_ff <= c_wrap[AW-1:0];
               emit_ff <= (r_wrap >= 2) || (r_wrap == 1 && c_wrap >= 1);
               if (eff_pixel) begin
                  px_ff <= {req.in_alpha, req.in_blue, req.in_green, req.in_red};
                  px_fac_ff <= (req.blend_factor > FB'(1 << FRAC_BITS))
                               ? FB'(1 << FRAC_BITS) : req.blend_factor;
               end else begin
                  px_ff <= '0;
                  px_fac_ff <= '0;
               end
               if (CW'(c_wrap + 1'b1) >= w_eff) begin
                  in_col_ff <= '0;
                  in_row_ff <= (RW+1)'(r_wrap + 1'b1);
               end else begin
                  in_col_ff <= CW'(c_wrap + 1'b1);
                  in_row_ff <= r_wrap;
               end
            end
            ST_READ: begin
               for (int r = 0; r < 3; r++) begin
                  win_ff[r][0] <= win_ff[r][1];
                  win_ff[r][1] <= win_ff[r][2];
               end
               win_ff[0][2] <= rd_two_ff;
               win_ff[1][2] <= rd_one_ff;
               win_ff[2][2] <= px_ff;
               win_fac_ff[0] <= win_fac_ff[1];
               win_fac_ff[1] <= win_fac_ff[2];
               win_fac_ff[2] <= rd_fac_ff;
            end
            ST_SHIFT: begin
               step_ff <= '0;
               for (int k = 0; k < 4; k++) acc_ff[k] <= '0;
            end
            ST_MAC: begin
               step_ff <= step_ff + 1'b1;
               for (int k = 0; k < 4; k++)
                  acc_ff[k] <= acc_ff[k] + ACCW'(win_ff[rsel[si]][csel[sj]][k] * wsel);
            end
            ST_BLEND: begin
               for (int k = 0; k < 4; k++)
                  bl_ff[k] <= BLW'(filt[k] * fac_s) + BLW'(win_ff[1][1][k] * onem_s)
                              + BLW'(1 << (FRAC_BITS-1));
            end
            ST_ROUND: if (out_free) begin
               out_done_ff <= frame_done_now;
               for (int k = 0; k < 4; k++) begin
                  if (bl_ff[k] < 0) out_ch_ff[k] <= '0;
                  else if ((bl_ff[k] >>> FRAC_BITS) > BLW'((1 << (CB-1)) - 1))
                     out_ch_ff[k] <= '1;
                  else out_ch_ff[k] <= (CB-1)'(bl_ff[k] >>> FRAC_BITS);
               end
               if (frame_done_now) begin
                  in_col_ff <= '0;
                  in_row_ff <= '0;
                  out_col_ff <= '0;
                  out_row_ff <= '0;
               end else if (CW'(out_col_ff + 1'b1) >= w_eff) begin
                  out_col_ff <= '0;
                  out_row_ff <= out_row_ff + 1'b1;
               end else begin
                  out_col_ff <= out_col_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.out_red = out_ch_ff[0];
   assign rsp.out_green = out_ch_ff[1];
   assign rsp.out_blue = out_ch_ff[2];
   assign rsp.out_alpha = out_ch_ff[3];
   assign rsp.frame_done = out_done_ff;

   // Checks
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == ST_IDLE) else $error("ready outside idle");
   a_mac_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BLEND |-> $past(step_ff) == 4'd8) else $error("mac count");
   a_result_reg: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND |=> out_valid_ff) else $error("result lost");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.out_red)
                                  && $stable(rsp.frame_done))
      else $error("overwrite");

endmodule

// File: sim/cbc_checker.sv
// Checker for the 3x3 convolution / blend / clamp unit: mirrors the registers,
// predicts every result from the request transfers and compares the responses.
// Depends on cbc_pkg and the stream interfaces in cbc_if.sv.
module cbc_checker
   import cbc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   cbc_req_if req,
   cbc_rsp_if rsp,
   input  logic csr_write_enable,
   input  logic [2:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_write_data,
   output int error_count,
   output int pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_MAX = MAX_WIDTH_DEF;
   localparam longint UNITY = 64'sd1 << FRAC_BITS_DEF;

   typedef struct packed {
      logic [3:0][15:0] ch;   // red, green, blue, alpha
      logic [12:0] fac;
   } pixel_type;

   typedef struct packed {
      logic [3:0][14:0] ch;
      logic done;
   } result_type;

   // register mirror
   logic [47:0] wt_row [3];
   logic [12:0] width_reg, height_reg;

   // pipeline state of the filter
   pixel_type line_one_up [LINE_MAX];
   pixel_type line_two_up [LINE_MAX];
   logic [12:0] factor_line [LINE_MAX];
   pixel_type win [3][3];
   int unsigned in_col, in_row, out_col, out_row;

   result_type expected_q[$];

   function automatic int unsigned eff_dim(logic [12:0] v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   // Advance the filter by one request transfer; queue a result if one falls out.
   task automatic filter_transfer(input logic op, input logic [3:0][15:0] data,
                                  input logic [12:0] factor);
      int unsigned w, h, c;
      int rr[3], cc[3];
      pixel_type px, top, mid, ctr;
      result_type res;
      longint acc, filt, v, fac;
      bit emit;
      w = eff_dim(width_reg, MAX_WIDTH_DEF);
      h = eff_dim(height_reg, MAX_HEIGHT_DEF);
      if (op == OP_DRAIN && in_row < h) return;   // early drain is ignored
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      c = in_col;
      px = '0;
      if (op == OP_PIXEL) begin
         px.ch = data;
         px.fac = (factor > 13'd4096) ? 13'd4096 : factor;
      end
      top = line_two_up[c];
      mid = line_one_up[c];
      mid.fac = factor_line[c];
      line_two_up[c] = mid;
      line_one_up[c] = px;
      factor_line[c] = px.fac;
      for (int r = 0; r < 3; r++) begin
         win[r][0] = win[r][1];
         win[r][1] = win[r][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = px;
      // emit decision uses the position the transfer was placed at
      emit = (in_row >= 2) || (in_row == 1 && c >= 1);
      if (c + 1 >= w) begin
         in_col = 0;
         in_row = (in_row + 1) & 32'h1FFF;
      end else begin
         in_col = c + 1;
      end
      if (!emit) return;

      // edge replication picks the center row/column at the borders
      rr[0] = (out_row == 0) ? 1 : 0;
      rr[1] = 1;
      rr[2] = (out_row + 1 >= h) ? 1 : 2;
      cc[0] = (out_col == 0) ? 1 : 0;
      cc[1] = 1;
      cc[2] = (out_col + 1 >= w) ? 1 : 2;
      ctr = win[1][1];
      fac = longint'(ctr.fac);
      for (int k = 0; k < 4; k++) begin
         acc = 0;
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               acc += longint'($signed(win[rr[i]][cc[j]].ch[k]))
                      * longint'($signed(wt_row[i][16*(2-j) +: 16]));
         filt = (acc + 2048) >>> FRAC_BITS_DEF;
         v = (filt * fac + longint'($signed(ctr.ch[k])) * (UNITY - fac) + 2048)
             >>> FRAC_BITS_DEF;
         if (v < 0) v = 0;
         if (v > 32767) v = 32767;
         res.ch[k] = v[14:0];
      end
      res.done = (out_col + 1 >= w) && (out_row + 1 >= h);
      expected_q.push_back(res);
      if (res.done) begin
         in_col = 0;
         in_row = 0;
         out_col = 0;
         out_row = 0;
      end else if (out_col + 1 >= w) begin
         out_col = 0;
         out_row++;
      end else begin
         out_col++;
      end
   endtask

   task automatic compare_field(string name, logic [14:0] exp_v, logic [14:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         wt_row[0] <= 48'd0;
         wt_row[1] <= 48'd4096;
         wt_row[2] <= 48'd0;
         width_reg <= 13'd4096;
         height_reg <= 13'd4096;
         in_col = 0;
         in_row = 0;
         out_col = 0;
         out_row = 0;
         for (int r = 0; r < 3; r++)
            for (int j = 0; j < 3; j++)
               win[r][j] = '0;
         expected_q.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               REG_WEIGHTS_TOP: wt_row[0] <= csr_write_data;
               REG_WEIGHTS_MID: wt_row[1] <= csr_write_data;
               REG_WEIGHTS_BOT: wt_row[2] <= csr_write_data;
               REG_FRAME_WIDTH: width_reg <= csr_write_data[12:0];
               REG_FRAME_HEIGHT: height_reg <= csr_write_data[12:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready)
            filter_transfer(req.opcode, {req.in_red, req.in_green, req.in_blue, req.in_alpha},
                            req.blend_factor);
         if (rsp.valid && rsp.ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: response transfer with no result expected", $time);
               error_count++;
            end else begin
               result_type e;
               e = expected_q.pop_front();
               compare_field("out_red", e.ch[3], rsp.out_red);
               compare_field("out_green", e.ch[2], rsp.out_green);
               compare_field("out_blue", e.ch[1], rsp.out_blue);
               compare_field("out_alpha", e.ch[0], rsp.out_alpha);
               compare_field("frame_done", 15'(e.done), 15'(rsp.frame_done));
            end
         end
      end
      pending_count = expected_q.size();
   end

endmodule

// File: sim/tb_conv3x3_blend_clamp_unit.sv
// Testbench top for conv3x3_blend_clamp_unit: clock, reset, register writes,
// framed pixel stimulus with bursts and response stalls, final verdict.
// Depends on cbc_pkg, cbc_if.sv, the unit and sim/cbc_checker.sv.
module tb_conv3x3_blend_clamp_unit;
   import cbc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int PIXEL_TARGET = 450;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [2:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_write_data;
   int error_count, pending_count;
   int cycle_count;
   int burst_left;

   cbc_req_if req ();
   cbc_rsp_if rsp ();

   conv3x3_blend_clamp_unit DUT (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   cbc_checker checker_inst (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .error_count(error_count),
      .pending_count(pending_count)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Receiver: short random stalls, quiet stretches, one long hold-off.
   int stall_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         stall_left = 0;
      end else if (cycle_count == 4000) begin
         stall_left = 700;
         rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
         if ((cycle_count / 3000) % 3 != 2 && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 15);
      end
   end

   function automatic int unsigned eff_dim(logic [12:0] v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic logic [15:0] pick_channel();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [12:0] pick_factor();
      case ($urandom_range(0, 5))
         0: return 13'd0;
         1: return 13'd4096;
         2: return 13'($urandom_range(4097, 8191));
         default: return 13'($urandom_range(0, 4096));
      endcase
   endfunction

   function automatic logic [47:0] pick_weights();
      logic [47:0] v;
      if ($urandom_range(0, 2) == 0) begin
         v = 48'({$urandom, $urandom});
      end else begin
         for (int j = 0; j < 3; j++)
            v[16*j +: 16] = 16'($signed($urandom_range(0, 4096)) - 2048);
      end
      return v;
   endfunction

   task automatic write_reg(csr_index_type idx, logic [47:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Wait until the unit has delivered everything and finished any idle work.
   task automatic wait_idle();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // One request transfer, with the sender working in random bursts.
   task automatic send(logic op, logic [15:0] r, logic [15:0] g, logic [15:0] b,
                       logic [15:0] a, logic [12:0] f);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req.valid <= 1'b1;
      req.opcode <= op;
      req.in_red <= r;
      req.in_green <= g;
      req.in_blue <= b;
      req.in_alpha <= a;
      req.blend_factor <= f;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic send_pixel();
      send(OP_PIXEL, pick_channel(), pick_channel(), pick_channel(), pick_channel(),
           pick_factor());
   endtask

   // A whole frame: pixels, an occasional early drain, then the flushing drains
   // (one of which may be a stray pixel that acts as a drain).
   task automatic run_frame(int unsigned w, int unsigned h);
      int unsigned early_at, stray_at;
      early_at = $urandom_range(0, w * h);
      stray_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, w) : w + 1;
      for (int unsigned n = 0; n < w * h; n++) begin
         if (n == early_at && n != 0)
            send(OP_DRAIN, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 13'($urandom));
         send_pixel();
      end
      for (int unsigned n = 0; n <= w; n++) begin
         if (n == stray_at) send_pixel();
         else send(OP_DRAIN, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   13'($urandom));
      end
      req.valid <= 1'b0;
      burst_left = 0;
      wait_idle();
   endtask

   task automatic setup_frame(logic [12:0] wv, logic [12:0] hv, bit new_weights);
      if (new_weights) begin
         write_reg(REG_WEIGHTS_TOP, pick_weights());
         write_reg(REG_WEIGHTS_MID, pick_weights());
         write_reg(REG_WEIGHTS_BOT, pick_weights());
      end
      write_reg(REG_FRAME_WIDTH, {35'd0, wv});
      write_reg(REG_FRAME_HEIGHT, {35'd0, hv});
      run_frame(eff_dim(wv, MAX_WIDTH_DEF), eff_dim(hv, MAX_HEIGHT_DEF));
   endtask

   initial begin
      int unsigned pixels_sent;
      logic [12:0] wv, hv;
      reset <= 1'b1;
      req.valid <= 1'b0;
      req.opcode <= OP_PIXEL;
      req.in_red <= '0;
      req.in_green <= '0;
      req.in_blue <= '0;
      req.in_alpha <= '0;
      req.blend_factor <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= REG_WEIGHTS_TOP;
      csr_write_data <= '0;
      burst_left = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset weights (unity on the middle-row right tap only), 3x3 frame with extreme values,
      // an early drain and a stray pixel among the drains
      write_reg(REG_FRAME_WIDTH, 48'd3);
      write_reg(REG_FRAME_HEIGHT, 48'd3);
      send(OP_PIXEL, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 13'd0);
      send(OP_PIXEL, 16'h8000, 16'h7FFF, 16'h1000, 16'h0001, 13'd4096);
      send(OP_PIXEL, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 13'd8191);
      send(OP_DRAIN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 13'h1FFF);
      send(OP_PIXEL, 16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF, 13'd2048);
      send(OP_PIXEL, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 13'd4097);
      send(OP_PIXEL, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 13'd1);
      send(OP_PIXEL, 16'hAAAA, 16'h5555, 16'h0FFF, 16'h0000, 13'd4095);
      send(OP_PIXEL, 16'h1234, 16'hEDCB, 16'h0800, 16'hF800, 13'd0);
      send(OP_PIXEL, 16'hFFFF, 16'h0001, 16'h7FFF, 16'h8000, 13'd4096);
      send(OP_DRAIN, '0, '0, '0, '0, '0);
      send(OP_PIXEL, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 13'd4096);
      send(OP_DRAIN, '0, '0, '0, '0, '0);
      send(OP_DRAIN, '0, '0, '0, '0, '0);
      req.valid <= 1'b0;
      burst_left = 0;
      wait_idle();

      // extreme weights: all most positive, then all most negative
      write_reg(REG_WEIGHTS_TOP, 48'h7FFF_7FFF_7FFF);
      write_reg(REG_WEIGHTS_MID, 48'h7FFF_7FFF_7FFF);
      write_reg(REG_WEIGHTS_BOT, 48'h7FFF_7FFF_7FFF);
      setup_frame(13'd4, 13'd3, 1'b0);
      write_reg(REG_WEIGHTS_TOP, 48'h8000_8000_8000);
      write_reg(REG_WEIGHTS_MID, 48'h8000_8000_8000);
      write_reg(REG_WEIGHTS_BOT, 48'h8000_8000_8000);
      setup_frame(13'd0, 13'd0, 1'b0);

      // random frames, mostly small
      pixels_sent = 0;
      while (pixels_sent < PIXEL_TARGET) begin
         wv = ($urandom_range(0, 15) == 0) ? 13'd0 : 13'($urandom_range(1, 8));
         hv = ($urandom_range(0, 15) == 0) ? 13'd0 : 13'($urandom_range(1, 6));
         setup_frame(wv, hv, 1'($urandom_range(0, 1)));
         pixels_sent += eff_dim(wv, MAX_WIDTH_DEF) * eff_dim(hv, MAX_HEIGHT_DEF);
      end

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
